@@ src/thi_pkg.sv @@
// Shared widths and beat types for the triangle height interpolator.
package thi_pkg;

	localparam int CW = 24;            // coordinate and height width
	localparam int DW = CW + 1;        // corner difference
	localparam int PW = 2 * DW;        // product of two differences
	localparam int SW = PW + 1;        // det, na, nb
	localparam int QB = DW + 1;        // quotient bits kept before saturation
	localparam int NW = SW + QB;       // weighted sum, also SW + DW + 1
	localparam int LB = (SW + 1) / 2;  // low slice of na/nb for the split multiply
	localparam int HW = SW - LB + DW;  // high-slice partial product
	localparam int LW = LB + 1 + DW;   // low-slice partial product
	localparam int RW = QB + 3;        // h2 plus signed quotient

	typedef struct packed {
		logic [CW-1:0] corner0_x;
		logic [CW-1:0] corner0_y;
		logic [CW-1:0] corner0_h;
		logic [CW-1:0] corner1_x;
		logic [CW-1:0] corner1_y;
		logic [CW-1:0] corner1_h;
		logic [CW-1:0] corner2_x;
		logic [CW-1:0] corner2_y;
		logic [CW-1:0] corner2_h;
		logic [CW-1:0] query_x;
		logic [CW-1:0] query_y;
	} thi_item_t;

	typedef struct packed {
		logic [CW-1:0] height;
		logic          valid_res;
	} thi_result_t;

	typedef struct packed {
		logic [SW-1:0] det;
		logic [SW-1:0] na;
		logic [SW-1:0] nb;
		logic [DW-1:0] dh0;
		logic [DW-1:0] dh1;
		logic [CW-1:0] h2;
	} thi_geo_t;

	typedef struct packed {
		logic [NW-1:0] an;
		logic [SW-1:0] ad;
		logic          neg;
		logic          zero;
		logic [CW-1:0] h2;
	} thi_num_t;

	typedef struct packed {
		logic [SW-1:0] rem;
		logic [QB-1:0] nlo;
		logic [QB-1:0] quo;
		logic [SW-1:0] ad;
		logic          neg;
		logic          zero;
		logic          ovf;
		logic [CW-1:0] h2;
	} thi_div_t;

endpackage

@@ src/thi_geom.sv @@
// Geometry stages: corner differences, pairwise products, det and weight numerators.
module thi_geom (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_i,
	input  thi_pkg::thi_item_t d_i,
	output logic               v_o,
	output thi_pkg::thi_geo_t  d_o
);
	import thi_pkg::*;

	function automatic logic signed [DW-1:0] sdiff(input logic [CW-1:0] a,
			input logic [CW-1:0] b);
		sdiff = DW'($signed(a)) - DW'($signed(b));
	endfunction

	function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		smul = PW'(a) * PW'(b);
	endfunction

	logic                 v_s1, v_s2, v_s3;
	logic signed [DW-1:0] dy12_s1, dx21_s1, dy20_s1, dx02_s1, dy02_s1;
	logic signed [DW-1:0] px_s1, py_s1, dh0_s1, dh1_s1;
	logic [CW-1:0]        h2_s1;
	logic signed [PW-1:0] pd0_s2, pd1_s2, pa0_s2, pa1_s2, pb0_s2, pb1_s2;
	logic [DW-1:0]        dh0_s2, dh1_s2;
	logic [CW-1:0]        h2_s2;
	thi_geo_t             geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dy12_s1 <= sdiff(d_i.corner1_y, d_i.corner2_y);
			dx21_s1 <= sdiff(d_i.corner2_x, d_i.corner1_x);
			dy20_s1 <= sdiff(d_i.corner2_y, d_i.corner0_y);
			dx02_s1 <= sdiff(d_i.corner0_x, d_i.corner2_x);
			dy02_s1 <= sdiff(d_i.corner0_y, d_i.corner2_y);
			px_s1   <= sdiff(d_i.query_x, d_i.corner2_x);
			py_s1   <= sdiff(d_i.query_y, d_i.corner2_y);
			dh0_s1  <= sdiff(d_i.corner0_h, d_i.corner2_h);
			dh1_s1  <= sdiff(d_i.corner1_h, d_i.corner2_h);
			h2_s1   <= d_i.corner2_h;

			pd0_s2 <= smul(dy12_s1, dx02_s1);
			pd1_s2 <= smul(dx21_s1, dy02_s1);
			pa0_s2 <= smul(dy12_s1, px_s1);
			pa1_s2 <= smul(dx21_s1, py_s1);
			pb0_s2 <= smul(dy20_s1, px_s1);
			pb1_s2 <= smul(dx02_s1, py_s1);
			dh0_s2 <= dh0_s1;
			dh1_s2 <= dh1_s1;
			h2_s2  <= h2_s1;

			geo_s3.det <= SW'(pd0_s2) + SW'(pd1_s2);
			geo_s3.na  <= SW'(pa0_s2) + SW'(pa1_s2);
			geo_s3.nb  <= SW'(pb0_s2) + SW'(pb1_s2);
			geo_s3.dh0 <= dh0_s2;
			geo_s3.dh1 <= dh1_s2;
			geo_s3.h2  <= h2_s2;
		end
	end

	assign v_o = v_s3;
	assign d_o = geo_s3;

endmodule

@@ src/thi_numer.sv @@
// Numerator stages: split multiply of weights by height deltas, sum, magnitudes.
module thi_numer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_i,
	input  thi_pkg::thi_geo_t d_i,
	output logic              v_o,
	output thi_pkg::thi_num_t d_o
);
	import thi_pkg::*;

	// na/nb are cut into a signed high slice and an unsigned low slice
	logic signed [SW-LB-1:0] nah, nbh;
	logic signed [LB:0]      nal, nbl;
	logic signed [DW-1:0]    dh0, dh1;

	logic                 v_s4, v_s5, v_s6;
	logic signed [HW-1:0] hh0_s4, hh1_s4;
	logic signed [LW-1:0] ll0_s4, ll1_s4;
	logic [SW-1:0]        det_s4;
	logic [CW-1:0]        h2_s4;
	logic signed [NW-1:0] num_s5;
	logic signed [SW-1:0] det_s5;
	logic                 zero_s5;
	logic [CW-1:0]        h2_s5;
	thi_num_t             num_s6;

	assign nah = $signed(d_i.na[SW-1:LB]);
	assign nbh = $signed(d_i.nb[SW-1:LB]);
	assign nal = $signed({1'b0, d_i.na[LB-1:0]});
	assign nbl = $signed({1'b0, d_i.nb[LB-1:0]});
	assign dh0 = $signed(d_i.dh0);
	assign dh1 = $signed(d_i.dh1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_i;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hh0_s4 <= HW'(nah) * HW'(dh0);
			hh1_s4 <= HW'(nbh) * HW'(dh1);
			ll0_s4 <= LW'(nal) * LW'(dh0);
			ll1_s4 <= LW'(nbl) * LW'(dh1);
			det_s4 <= d_i.det;
			h2_s4  <= d_i.h2;

			num_s5  <= ((NW'(hh0_s4) + NW'(hh1_s4)) <<< LB) + NW'(ll0_s4) + NW'(ll1_s4);
			det_s5  <= $signed(det_s4);
			zero_s5 <= (det_s4 == '0);
			h2_s5   <= h2_s4;

			num_s6.an   <= num_s5[NW-1] ? NW'(-num_s5) : NW'(num_s5);
			num_s6.ad   <= det_s5[SW-1] ? SW'(-det_s5) : SW'(det_s5);
			num_s6.neg  <= num_s5[NW-1] ^ det_s5[SW-1];
			num_s6.zero <= zero_s5;
			num_s6.h2   <= h2_s5;
		end
	end

	assign v_o = v_s6;
	assign d_o = num_s6;

endmodule

@@ src/thi_div_step.sv @@
// One restoring-division stage: one quotient bit per stage.
module thi_div_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_i,
	input  thi_pkg::thi_div_t d_i,
	output logic              v_o,
	output thi_pkg::thi_div_t d_o
);
	import thi_pkg::*;

	logic [SW:0]   trial;
	logic [SW:0]   diff;
	logic          ge;
	logic          v_sn;
	thi_div_t      d_sn;

	assign trial = {d_i.rem, d_i.nlo[QB-1]};
	assign diff  = trial - {1'b0, d_i.ad};
	assign ge    = (trial >= {1'b0, d_i.ad});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (en) begin
			v_sn <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_sn.rem  <= ge ? diff[SW-1:0] : trial[SW-1:0];
			d_sn.nlo  <= {d_i.nlo[QB-2:0], 1'b0};
			d_sn.quo  <= {d_i.quo[QB-2:0], ge};
			d_sn.ad   <= d_i.ad;
			d_sn.neg  <= d_i.neg;
			d_sn.zero <= d_i.zero;
			d_sn.ovf  <= d_i.ovf;
			d_sn.h2   <= d_i.h2;
		end
	end

	assign v_o = v_sn;
	assign d_o = d_sn;

	// partial remainder must stay below the divisor on every live beat
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(v_sn && !d_sn.zero && !d_sn.ovf) |-> (d_sn.rem < d_sn.ad))
		else $error("division remainder not below divisor");

endmodule

@@ src/thi_div.sv @@
// Divider pipeline: range check, quotient step chain, rounding and saturation.
module thi_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_i,
	input  thi_pkg::thi_num_t    d_i,
	output logic                 v_o,
	output thi_pkg::thi_result_t d_o
);
	import thi_pkg::*;

	localparam logic [CW-1:0] HMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] HMIN = {1'b1, {(CW-1){1'b0}}};

	logic                 v_s7;
	thi_div_t             prep_s7;
	logic [QB:0]          cv;
	thi_div_t             cd [QB+1];

	logic [QB:0]          qr;
	logic signed [QB+1:0] qx;
	logic                 up;
	thi_div_t             last;

	logic                 v_s34, v_s35;
	logic signed [QB+1:0] sq_s34;
	logic [CW-1:0]        h2_s34;
	logic                 zero_s34, ovf_s34, neg_s34;
	thi_result_t          res_s35;

	logic signed [RW-1:0] sum;
	logic [RW-CW:0]       top;
	logic                 sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
		end else if (en) begin
			v_s7  <= v_i;
			v_s34 <= cv[QB];
			v_s35 <= v_s34;
		end
	end

	// quotient wider than QB bits saturates the result outright
	always_ff @(posedge clk) begin
		if (en) begin
			prep_s7.rem  <= d_i.an[NW-1:QB];
			prep_s7.nlo  <= d_i.an[QB-1:0];
			prep_s7.quo  <= '0;
			prep_s7.ad   <= d_i.ad;
			prep_s7.neg  <= d_i.neg;
			prep_s7.zero <= d_i.zero;
			prep_s7.ovf  <= (d_i.an >= {d_i.ad, {QB{1'b0}}});
			prep_s7.h2   <= d_i.h2;
		end
	end

	assign cv[0] = v_s7;
	assign cd[0] = prep_s7;

	for (genvar g = 0; g < QB; g++) begin : g_step
		thi_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (cv[g]),
			.d_i    (cd[g]),
			.v_o    (cv[g+1]),
			.d_o    (cd[g+1])
		);
	end

	// round half away from zero on the magnitude, then restore the sign
	assign last = cd[QB];
	assign up   = ({last.rem, 1'b0} >= {1'b0, last.ad});
	assign qr   = {1'b0, last.quo} + {{QB{1'b0}}, up};
	assign qx   = $signed({1'b0, qr});

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s34   <= last.neg ? -qx : qx;
			h2_s34   <= last.h2;
			zero_s34 <= last.zero;
			ovf_s34  <= last.ovf;
			neg_s34  <= last.neg;
		end
	end

	assign sum = RW'(sq_s34) + RW'($signed(h2_s34));
	assign top = sum[RW-1:CW-1];
	assign sat = !((&top) || !(|top));

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s34) begin
				res_s35.height    <= '0;
				res_s35.valid_res <= 1'b0;
			end else begin
				res_s35.valid_res <= 1'b1;
				if (ovf_s34) begin
					res_s35.height <= neg_s34 ? HMIN : HMAX;
				end else if (sat) begin
					res_s35.height <= sum[RW-1] ? HMIN : HMAX;
				end else begin
					res_s35.height <= sum[CW-1:0];
				end
			end
		end
	end

	assign v_o = v_s35;
	assign d_o = res_s35;

endmodule

@@ src/thi_skid.sv @@
// Output register with one skid entry; decouples pipeline advance from result stall.
module thi_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 v_i,
	input  thi_pkg::thi_result_t d_i,
	input  logic                 result_stall,
	output logic                 result_valid,
	output thi_pkg::thi_result_t result,
	output logic                 full
);
	import thi_pkg::*;

	logic        res_valid_q, skid_full_q;
	thi_result_t res_q, skid_q;
	logic        out_free, arrive;

	assign out_free = !res_valid_q || !result_stall;
	// the pipeline is frozen while the skid entry is occupied
	assign arrive   = v_i && !skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_free) begin
			if (skid_full_q) begin
				res_valid_q <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				res_valid_q <= arrive;
			end
		end else if (arrive) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= skid_full_q ? skid_q : d_i;
		end else if (arrive) begin
			skid_q <= d_i;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign full         = skid_full_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> res_valid_q)
		else $error("skid entry held with output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && !result_stall) |=> !skid_full_q)
		else $error("skid entry not drained after output taken");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.valid_res) |-> (res_q.height == '0))
		else $error("degenerate triangle gave nonzero height");

endmodule

@@ src/triangle_height_interpolation.sv @@
// Top level of the barycentric triangle height interpolator.
//
// Input channel (item_valid / item_stall / item): one beat carries three
// triangle corners (x, y, height) and a query point, all signed fixed point
// with 8 fraction bits. Output channel (result_valid / result_stall /
// result): one beat per input beat, in order, with the interpolated height
// (rounded half away from zero, saturated) and valid_res, which is 0 with a
// height of 0 when the triangle is degenerate (zero determinant).
//
// Throughput: one beat per cycle while item_stall is low. The bulk of the
// pipeline is the divider, one quotient bit per stage over 26 stages, after
// 3 geometry, 3 numerator and 1 range-check stage, with rounding, saturation
// and the output register behind it.
//
// Reset clears every valid bit; the pipeline comes up empty and item_stall
// low. When the receiver stalls, the output register holds its beat and one
// more beat lands in a skid entry; item_stall then rises and the whole
// pipeline freezes in place until the output is taken.
module triangle_height_interpolation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  thi_pkg::thi_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output thi_pkg::thi_result_t result
);
	import thi_pkg::*;

	logic        en;        // global pipeline advance
	logic        skid_full;
	logic        geo_v, num_v, div_v;
	thi_geo_t    geo_d;
	thi_num_t    num_d;
	thi_result_t div_d;

	// registered stall: no combinational path from result_stall to item_stall
	assign en         = !skid_full;
	assign item_stall = skid_full;

	// corner differences, products, det / na / nb
	thi_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (item_valid),
		.d_i    (item),
		.v_o    (geo_v),
		.d_o    (geo_d)
	);

	// weighted height sum and magnitudes for the divider
	thi_numer u_numer (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (geo_v),
		.d_i    (geo_d),
		.v_o    (num_v),
		.d_o    (num_d)
	);

	// quotient, rounding, add corner2 height, saturate
	thi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (num_v),
		.d_i    (num_d),
		.v_o    (div_v),
		.d_o    (div_d)
	);

	thi_skid u_skid (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_i          (div_v),
		.d_i          (div_d),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.full         (skid_full)
	);

endmodule

@@ verif/triangle_height_interpolation_tb.sv @@
// Self-checking testbench for the triangle height interpolator, with a local bit-exact model.
`timescale 1ns / 100ps

module triangle_height_interpolation_tb;
	import thi_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	localparam int MAX_IDLE     = 18;
	localparam int DRAIN_CYCLES = 60;      // comfortably past the pipeline latency
	localparam int HOLD_CYCLES  = 400;     // long receiver hold-off, well past what the pipeline and skid entry can hold
	localparam int CYCLE_LIMIT  = 200000;  // watchdog limit for the whole run
	localparam int MAX_REPORTS  = 200;     // keep a broken run's log readable
	localparam int RANDOM_BEATS = 450;
	localparam int STREAM_BEATS = 100;
	localparam int FILL_BEATS   = 80;
	localparam int V_MAX        = (1 << (CW - 1)) - 1;
	localparam int V_MIN        = -(1 << (CW - 1));

	// Flavours of random triangle; the bulk are well-formed, small enough to interpolate.
	typedef enum int {
		SHAPE_WILD,       // every field random across the full range
		SHAPE_LOCAL,      // compact triangle, query close by
		SHAPE_FLAT,       // zero-area triangle
		SHAPE_ON_CORNER,  // query sits exactly on a corner
		SHAPE_STEEP       // extreme heights, query anywhere: drives saturation
	} shape_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	thi_item_t   item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	thi_result_t result;

	thi_result_t heights_due[$];  // predicted results, oldest first

	bit   src_idle    = 1'b1;  // sender draws gaps between beats
	bit   sink_idle   = 1'b1;  // receiver draws stalls between beats
	bit   hold_active = 1'b0;
	event hold_req;

	int sink_wait       = 0;
	int errors          = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int flat_count      = 0;
	int clip_count      = 0;
	int directed_count  = 0;
	int cycle_count     = 0;

	triangle_height_interpolation dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Height at the query point: h2 + (na*(h0-h2) + nb*(h1-h2)) / det, all exact,
	// quotient rounded half away from zero, then clipped to the height range.
	function automatic thi_result_t interp_height(thi_item_t it);
		logic signed [127:0] x0, y0, h0, x1, y1, h1, x2, y2, h2, qx, qy;
		logic signed [127:0] det, na, nb, num, hgt, top, bottom;
		logic [127:0]        mag_num, mag_det, quo, rmd;
		thi_result_t         r;
		x0 = $signed(it.corner0_x);
		y0 = $signed(it.corner0_y);
		h0 = $signed(it.corner0_h);
		x1 = $signed(it.corner1_x);
		y1 = $signed(it.corner1_y);
		h1 = $signed(it.corner1_h);
		x2 = $signed(it.corner2_x);
		y2 = $signed(it.corner2_y);
		h2 = $signed(it.corner2_h);
		qx = $signed(it.query_x);
		qy = $signed(it.query_y);
		top    = V_MAX;
		bottom = V_MIN;
		r      = '0;
		det = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
		// zero area: height 0, flag cleared
		if (det == 0)
			return r;
		na  = (y1 - y2) * (qx - x2) + (x2 - x1) * (qy - y2);
		nb  = (y2 - y0) * (qx - x2) + (x0 - x2) * (qy - y2);
		num = na * (h0 - h2) + nb * (h1 - h2);
		mag_num = (num < 0) ? -num : num;
		mag_det = (det < 0) ? -det : det;
		quo = mag_num / mag_det;
		rmd = mag_num % mag_det;
		if ((rmd << 1) >= mag_det)
			quo = quo + 1;
		hgt = ((num < 0) != (det < 0)) ? h2 - $signed(quo) : h2 + $signed(quo);
		if (hgt > top)
			hgt = top;
		if (hgt < bottom)
			hgt = bottom;
		r.height    = hgt[CW-1:0];
		r.valid_res = 1'b1;
		return r;
	endfunction

	function automatic logic [CW-1:0] any_word();
		return CW'($urandom);
	endfunction

	function automatic logic [CW-1:0] near(logic [CW-1:0] base, int unsigned span);
		return base + CW'($urandom_range(0, 2 * span)) - CW'(span);
	endfunction

	function automatic logic [CW-1:0] steep_height();
		case ($urandom_range(0, 3))
			0: return CW'(V_MAX);
			1: return CW'(V_MIN);
			2: return '0;
			default: return any_word();
		endcase
	endfunction

	function automatic thi_item_t triangle(int x0, int y0, int h0, int x1, int y1, int h1,
			int x2, int y2, int h2, int qx, int qy);
		thi_item_t it;
		it.corner0_x = CW'(x0);
		it.corner0_y = CW'(y0);
		it.corner0_h = CW'(h0);
		it.corner1_x = CW'(x1);
		it.corner1_y = CW'(y1);
		it.corner1_h = CW'(h1);
		it.corner2_x = CW'(x2);
		it.corner2_y = CW'(y2);
		it.corner2_h = CW'(h2);
		it.query_x   = CW'(qx);
		it.query_y   = CW'(qy);
		return it;
	endfunction

	function automatic thi_item_t random_triangle(shape_t shape);
		thi_item_t     it;
		logic [CW-1:0] cx, cy, dx, dy;
		int unsigned   span;
		span = 1 << $urandom_range(1, 20);
		cx   = any_word();
		cy   = any_word();
		it.corner0_x = near(cx, span);
		it.corner0_y = near(cy, span);
		it.corner1_x = near(cx, span);
		it.corner1_y = near(cy, span);
		it.corner2_x = near(cx, span);
		it.corner2_y = near(cy, span);
		it.corner0_h = any_word();
		it.corner1_h = any_word();
		it.corner2_h = any_word();
		it.query_x   = near(cx, span);
		it.query_y   = near(cy, span);
		case (shape)
			SHAPE_WILD: begin
				it.corner0_x = any_word();
				it.corner0_y = any_word();
				it.corner1_x = any_word();
				it.corner1_y = any_word();
				it.corner2_x = any_word();
				it.corner2_y = any_word();
				it.query_x   = any_word();
				it.query_y   = any_word();
			end
			SHAPE_FLAT: begin
				// kept away from the range ends so the points really are collinear
				it.corner0_x = near('0, 1 << 21);
				it.corner0_y = near('0, 1 << 21);
				dx = near('0, 1 << 19);
				dy = near('0, 1 << 19);
				case ($urandom_range(0, 2))
					0: begin
						it.corner1_x = it.corner0_x + dx;
						it.corner1_y = it.corner0_y + dy;
						it.corner2_x = it.corner0_x - dx - dx;
						it.corner2_y = it.corner0_y - dy - dy;
					end
					1: begin
						it.corner2_x = it.corner0_x;
						it.corner2_y = it.corner0_y;
					end
					default: begin
						it.corner1_x = it.corner0_x;
						it.corner1_y = it.corner0_y;
						it.corner2_x = it.corner0_x;
						it.corner2_y = it.corner0_y;
					end
				endcase
				if ($urandom_range(0, 1)) begin
					it.query_x = any_word();
					it.query_y = any_word();
				end
			end
			SHAPE_ON_CORNER: begin
				case ($urandom_range(0, 2))
					0: begin
						it.query_x = it.corner0_x;
						it.query_y = it.corner0_y;
					end
					1: begin
						it.query_x = it.corner1_x;
						it.query_y = it.corner1_y;
					end
					default: begin
						it.query_x = it.corner2_x;
						it.query_y = it.corner2_y;
					end
				endcase
			end
			SHAPE_STEEP: begin
				it.corner0_h = steep_height();
				it.corner1_h = steep_height();
				it.corner2_h = steep_height();
				if ($urandom_range(0, 1)) begin
					it.query_x = any_word();
					it.query_y = any_word();
				end
			end
			default: ;
		endcase
		return it;
	endfunction

	// One input beat: optional gap, then hold it on the bus until taken.
	// Expectation is queued at the accepting edge, long before the result can appear.
	task automatic send_item(input thi_item_t it);
		int          gap;
		thi_result_t due;
		gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		due = interp_height(it);
		heights_due.push_back(due);
		items_sent++;
		if (!due.valid_res)
			flat_count++;
		else if ($signed(due.height) == V_MAX || $signed(due.height) == V_MIN)
			clip_count++;
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		if (errors < MAX_REPORTS)
			$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// Result side: check every accepted beat, then draw the stall before the next one.
	always @(posedge clk) begin : result_sink
		thi_result_t want;
		if (result_valid && !result_stall) begin
			if (heights_due.size() == 0) begin
				if (errors < MAX_REPORTS)
					$error("result beat with nothing outstanding: height %0d valid_res %0b",
						$signed(result.height), result.valid_res);
				errors++;
			end else begin
				want = heights_due.pop_front();
				if (result.height !== want.height) begin
					report_mismatch("height", $signed(want.height), $signed(result.height));
					errors++;
				end
				if (result.valid_res !== want.valid_res) begin
					report_mismatch("valid_res", want.valid_res, result.valid_res);
					errors++;
				end
				results_checked++;
			end
			sink_wait = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
		end
		if (hold_active || sink_wait > 0)
			result_stall <= 1'b1;
		else
			result_stall <= 1'b0;
		if (sink_wait > 0)
			sink_wait--;
	end

	// Long receiver hold-off, timed here so the sender keeps pushing meanwhile.
	initial begin : hold_timer
		forever begin
			@(hold_req);
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active = 1'b0;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, heights_due.size());
			$display("triangle_height_interpolation: mismatch");
			$finish;
		end
	end

	// Range ends, degenerate shapes, both winding orders, rounding ties,
	// saturation at both ends and plain extrapolation.
	task automatic test_directed();
		send_item(triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(triangle(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX,
			V_MAX, V_MAX));
		send_item(triangle(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN,
			V_MIN, V_MIN));
		send_item(triangle(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		// unit right triangle, query on a corner and at the centroid
		send_item(triangle(0, 0, 256, 256, 0, 512, 0, 256, 768, 0, 0));
		send_item(triangle(0, 0, 256, 256, 0, 512, 0, 256, 768, 85, 85));
		// half-way ties, both signs
		send_item(triangle(0, 0, 1, 2, 0, 0, 0, 2, 0, 1, 0));
		send_item(triangle(0, 0, -1, 2, 0, 0, 0, 2, 0, 1, 0));
		send_item(triangle(0, 0, 3, 2, 0, 0, 0, 2, 0, 1, 0));
		// opposite winding gives a negative determinant
		send_item(triangle(256, 0, 512, 0, 0, 256, 0, 256, 768, 85, 85));
		// collinear and coincident corners
		send_item(triangle(0, 0, 100, 100, 100, 200, 200, 200, 300, 50, 70));
		send_item(triangle(10, 20, 5, 10, 20, 6, 300, -40, 7, 1, 1));
		// largest determinant the fields allow
		send_item(triangle(V_MIN, V_MIN, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN, V_MAX, 0,
			V_MAX, V_MAX));
		send_item(triangle(V_MIN, V_MIN, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN,
			0, 0));
		// far extrapolation past both ends of the height range
		send_item(triangle(0, 0, V_MAX, 1, 0, 0, 0, 1, 0, V_MIN, V_MIN));
		send_item(triangle(0, 0, V_MIN, 1, 0, 0, 0, 1, 0, V_MIN, V_MIN));
		// modest extrapolation that stays in range
		send_item(triangle(0, 0, 0, 256, 0, 256, 0, 256, 0, 1024, 0));
		// alternating bit patterns
		send_item(triangle('h555555, 'haaaaaa, 'h555555, 'haaaaaa, 'h555555, 'haaaaaa,
			'h123456, 'h654321, 'haaaaaa, 'h555555, 'haaaaaa));
		send_item(triangle(16, -16, V_MAX, -16, 16, V_MIN, 40, 40, V_MAX, 3, -2));
		send_item(triangle(-300, 500, 1234, 700, -200, -4321, 9, 9, 77, 9, 9));
		directed_count = items_sent;
	endtask

	// Bulk of the run: mostly well-formed triangles, idling switched per block.
	task automatic test_random_mix();
		shape_t shape;
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i % 50 == 0) begin
				src_idle  = ($urandom_range(0, 3) != 0);
				sink_idle = ($urandom_range(0, 3) != 0);
			end
			case ($urandom_range(0, 9))
				0, 1:       shape = SHAPE_WILD;
				2, 3, 4, 5: shape = SHAPE_LOCAL;
				6:          shape = SHAPE_FLAT;
				7:          shape = SHAPE_ON_CORNER;
				default:    shape = SHAPE_STEEP;
			endcase
			send_item(random_triangle(shape));
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	// Receiver goes quiet while the sender streams: the pipeline fills and
	// item_stall has to rise and hold every beat in place.
	task automatic test_back_pressure();
		src_idle = 1'b0;
		-> hold_req;
		for (int i = 0; i < FILL_BEATS; i++)
			send_item(random_triangle(($urandom_range(0, 1) != 0) ? SHAPE_LOCAL : SHAPE_WILD));
		src_idle = 1'b1;
	endtask

	// Back-to-back on both sides, at the full rate.
	task automatic test_streaming();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		for (int i = 0; i < STREAM_BEATS; i++)
			send_item(random_triangle(shape_t'($urandom_range(0, 4))));
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_back_pressure();
		test_streaming();
		item_valid <= 1'b0;
		while (heights_due.size() != 0) @(posedge clk);
		// anything arriving now is an unrequested beat
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d triangles (%0d directed), %0d of them zero-area, %0d clipped",
			items_sent, directed_count, flat_count, clip_count);
		$display("checked %0d results, incl. a %0d-cycle receiver hold with the input stalled",
			results_checked, HOLD_CYCLES);
		if (errors == 0)
			$display("triangle_height_interpolation: match");
		else
			$display("triangle_height_interpolation: mismatch");
		$finish;
	end

endmodule
